@@ hw/rtl/sbr_pkg.sv @@
// ----------------------------------------------------------------------------
// Stack blur row filter package
// Widths, coefficient tables and the types shared by the filter modules.
// ----------------------------------------------------------------------------
package sbr_pkg;

    localparam int MAX_RADIUS   = 31;
    localparam int MIN_RADIUS   = 2;
    localparam int RESET_RADIUS = 2;

    localparam int PIX_W     = 8;
    localparam int PIX_MAX   = 2 ** PIX_W - 1;
    localparam int RADIUS_W  = $clog2(MAX_RADIUS + 1);
    localparam int RP1_W     = $clog2(MAX_RADIUS + 2);
    localparam int CNT_W     = RADIUS_W + 1;
    localparam int CNT_MAX   = 2 * MAX_RADIUS + 1;
    localparam int WIN_DEPTH = 2 ** CNT_W;

    localparam int TAB_DEPTH = 64;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);
    localparam int MUL_W     = 10;
    localparam int SHR_W     = 5;

    localparam int SQ_W   = $clog2((MAX_RADIUS + 1) * (MAX_RADIUS + 1) + 1);
    localparam int SIDE_W = $clog2(PIX_MAX * (MAX_RADIUS + 1) + 1);
    localparam int SUM_W  = $clog2(PIX_MAX * (MAX_RADIUS + 1) * (MAX_RADIUS + 1) + 1);
    localparam int PROD_W = SUM_W + MUL_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QUEUE_AW + 1;

    localparam logic [MUL_W-1:0] MUL_TAB [TAB_DEPTH] = '{
        10'd512, 10'd512, 10'd456, 10'd512, 10'd328, 10'd456, 10'd335, 10'd512,
        10'd405, 10'd328, 10'd271, 10'd456, 10'd388, 10'd335, 10'd292, 10'd512,
        10'd454, 10'd405, 10'd364, 10'd328, 10'd298, 10'd271, 10'd496, 10'd456,
        10'd420, 10'd388, 10'd360, 10'd335, 10'd312, 10'd292, 10'd273, 10'd512,
        10'd482, 10'd454, 10'd428, 10'd405, 10'd383, 10'd364, 10'd345, 10'd328,
        10'd312, 10'd298, 10'd284, 10'd271, 10'd259, 10'd496, 10'd475, 10'd456,
        10'd437, 10'd420, 10'd404, 10'd388, 10'd374, 10'd360, 10'd347, 10'd335,
        10'd323, 10'd312, 10'd302, 10'd292, 10'd282, 10'd273, 10'd265, 10'd512
    };

    localparam logic [SHR_W-1:0] SHR_TAB [TAB_DEPTH] = '{
        5'd9,  5'd11, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15,
        5'd15, 5'd15, 5'd15, 5'd16, 5'd16, 5'd16, 5'd16, 5'd17,
        5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd18, 5'd18,
        5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd19,
        5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19,
        5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd20, 5'd20, 5'd20,
        5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20,
        5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd21
    };

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] wp;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [MUL_W-1:0]    mul;
        logic [SHR_W-1:0]    shr;
        logic [SQ_W-1:0]     sq;
        logic [RP1_W-1:0]    rp1;
    } t_cfg;

    function automatic logic [RADIUS_W-1:0] clamp_radius(input logic [RADIUS_W-1:0] value);
        logic [RADIUS_W-1:0] res;
        res = value;
        if (value < RADIUS_W'(MIN_RADIUS)) begin
            res = RADIUS_W'(MIN_RADIUS);
        end else if (value > RADIUS_W'(MAX_RADIUS)) begin
            res = RADIUS_W'(MAX_RADIUS);
        end
        return res;
    endfunction

    function automatic t_cfg make_cfg(input logic [RADIUS_W-1:0] radius);
        t_cfg             cfg;
        logic [RP1_W-1:0] rp1;
        rp1        = RP1_W'(radius) + RP1_W'(1);
        cfg.radius = radius;
        cfg.mul    = MUL_TAB[TAB_AW'(radius)];
        cfg.shr    = SHR_TAB[TAB_AW'(radius)];
        cfg.sq     = SQ_W'(rp1) * SQ_W'(rp1);
        cfg.rp1    = rp1;
        return cfg;
    endfunction

endpackage

@@ hw/rtl/sbr_front.sv @@
// ----------------------------------------------------------------------------
// Stack blur front end
// Holds the radius register, numbers the pixels of each row and forms queue
// commands.
// ----------------------------------------------------------------------------
module sbr_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [sbr_pkg::PIX_W-1:0]    i_pixel_in,
    input  logic                         i_row_end,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sbr_pkg::RADIUS_W-1:0] i_blur_radius,
    input  logic                         i_q_ready,
    output logic                         o_push,
    output sbr_pkg::t_cmd                o_cmd,
    output sbr_pkg::t_cfg                o_cfg
);

    logic [sbr_pkg::CNT_W-1:0] r_cnt;
    logic [sbr_pkg::CNT_W-1:0] r_wp;
    logic [sbr_pkg::CNT_W-1:0] n_cnt;
    sbr_pkg::t_cfg             r_cfg;
    logic                      accept;

    assign o_in_ready  = i_q_ready;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && i_q_ready;
    assign o_push      = accept;
    assign o_cfg       = r_cfg;

    always_comb begin
        o_cmd.pix  = i_pixel_in;
        o_cmd.cnt  = r_cnt;
        o_cmd.wp   = r_wp;
        o_cmd.last = i_row_end;
        n_cnt      = (r_cnt == sbr_pkg::CNT_W'(sbr_pkg::CNT_MAX)) ?
                     r_cnt : r_cnt + sbr_pkg::CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_cfg <= sbr_pkg::make_cfg(sbr_pkg::RADIUS_W'(sbr_pkg::RESET_RADIUS));
        end else if (i_cfg_valid) begin
            r_cfg <= sbr_pkg::make_cfg(sbr_pkg::clamp_radius(i_blur_radius));
            r_cnt <= '0;
            r_wp  <= '0;
        end else if (accept) begin
            if (i_row_end) begin
                r_cnt <= '0;
                r_wp  <= '0;
            end else begin
                r_cnt <= n_cnt;
                r_wp  <= r_wp + sbr_pkg::CNT_W'(1);
            end
        end
    end

endmodule

@@ hw/rtl/sbr_queue.sv @@
// ----------------------------------------------------------------------------
// Stack blur command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sbr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sbr_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output sbr_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    sbr_pkg::t_cmd                r_mem [sbr_pkg::QUEUE_DEPTH];
    logic [sbr_pkg::QUEUE_AW-1:0] r_wr;
    logic [sbr_pkg::QUEUE_AW-1:0] r_rd;
    logic [sbr_pkg::QCNT_W-1:0]   r_cnt;
    logic                         push_ok;
    logic                         pop_ok;

    assign o_ready = (r_cnt != sbr_pkg::QCNT_W'(sbr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + sbr_pkg::QUEUE_AW'(1);
            end
            if (pop_ok) begin
                r_rd <= r_rd + sbr_pkg::QUEUE_AW'(1);
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + sbr_pkg::QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - sbr_pkg::QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hw/rtl/sbr_back.sv @@
// ----------------------------------------------------------------------------
// Stack blur back end
// Runs the running-sum recurrence over the pixel window, expands the row end
// flush and scales each weighted sum into an output pixel.
// ----------------------------------------------------------------------------
module sbr_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  sbr_pkg::t_cmd             i_q_cmd,
    output logic                      o_q_pop,
    input  sbr_pkg::t_cfg             i_cfg,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [sbr_pkg::PIX_W-1:0] o_pixel_out,
    output logic                      o_row_last
);

    localparam int PW = sbr_pkg::PIX_W;
    localparam int CW = sbr_pkg::CNT_W;
    localparam int RW = sbr_pkg::RADIUS_W;
    localparam int SW = sbr_pkg::SUM_W;
    localparam int DW = sbr_pkg::SIDE_W;
    localparam int XW = sbr_pkg::PROD_W;

    // Flush sequencer.
    logic [RW-1:0] r_fl;
    logic [CW-1:0] r_vn;
    logic [CW-1:0] r_vwp;
    logic [PW-1:0] r_plast;

    // Window memory.
    logic [PW-1:0] r_win [sbr_pkg::WIN_DEPTH];
    logic [PW-1:0] r_rd_old;
    logic [PW-1:0] r_rd_mid;

    // Sum stage.
    logic          r_v1;
    logic          r_first1;
    logic          r_emit1;
    logic          r_last1;
    logic          r_oldc1;
    logic [PW-1:0] r_pin1;
    logic [PW-1:0] r_p0;
    logic [SW-1:0] r_s;
    logic [DW-1:0] r_a;
    logic [DW-1:0] r_b;

    // Scale and output stages.
    logic          r_v2;
    logic [SW-1:0] r_s2;
    logic          r_last2;
    logic          r_v3;
    logic [XW-1:0] r_prod;
    logic          r_last3;
    logic          r_v4;
    logic [PW-1:0] r_pix4;
    logic          r_last4;

    logic          en;
    logic          flushing;
    logic          take;
    logic          s0_valid;
    logic [CW-1:0] s0_cnt;
    logic [CW-1:0] s0_wp;
    logic [PW-1:0] s0_pin;
    logic          s0_first;
    logic          s0_last;
    logic          s0_emit;
    logic          s0_oldc;
    logic [CW-1:0] span;
    logic [CW-1:0] addr_old;
    logic [CW-1:0] addr_mid;
    logic [CW-1:0] n_vn;
    logic [CW-1:0] n_vwp;

    logic [PW-1:0] old_pix;
    logic [PW-1:0] mid_pix;
    logic [SW-1:0] s_init;
    logic [DW-1:0] a_init;
    logic [SW-1:0] s_new;
    logic [DW-1:0] a_new;
    logic [DW-1:0] b_new;

    assign en       = !r_v4 || i_out_ready;
    assign flushing = (r_fl != '0);
    assign take     = en && !flushing && i_q_valid;
    assign o_q_pop  = take;
    assign s0_valid = flushing || i_q_valid;

    always_comb begin
        s0_cnt   = flushing ? r_vn    : i_q_cmd.cnt;
        s0_wp    = flushing ? r_vwp   : i_q_cmd.wp;
        s0_pin   = flushing ? r_plast : i_q_cmd.pix;
        s0_first = !flushing && (i_q_cmd.cnt == '0);
        s0_last  = flushing && (r_fl == RW'(1));
        span     = {i_cfg.radius, 1'b1};
        s0_emit  = (s0_cnt >= CW'(i_cfg.radius));
        s0_oldc  = (s0_cnt < span);
        addr_old = s0_wp - span;
        addr_mid = s0_wp - CW'(i_cfg.radius);
        n_vn     = (s0_cnt == CW'(sbr_pkg::CNT_MAX)) ? s0_cnt : s0_cnt + CW'(1);
        n_vwp    = s0_wp + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fl <= '0;
        end else if (take && i_q_cmd.last) begin
            r_fl <= i_cfg.radius;
        end else if (en && flushing) begin
            r_fl <= r_fl - RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_q_cmd.last) begin
            r_vn    <= n_vn;
            r_vwp   <= n_vwp;
            r_plast <= i_q_cmd.pix;
        end else if (en && flushing) begin
            r_vn  <= n_vn;
            r_vwp <= n_vwp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_win[s0_wp] <= i_q_cmd.pix;
        end
        if (en) begin
            r_rd_old <= r_win[addr_old];
            r_rd_mid <= r_win[addr_mid];
        end
    end

    always_comb begin
        old_pix = r_oldc1 ? r_p0 : r_rd_old;
        mid_pix = r_emit1 ? r_rd_mid : r_p0;
        s_init  = SW'(r_pin1) * SW'(i_cfg.sq);
        a_init  = DW'(r_pin1) * DW'(i_cfg.rp1);
        if (r_first1) begin
            s_new = s_init;
            a_new = a_init;
            b_new = a_init - DW'(r_pin1);
        end else begin
            s_new = r_s - SW'(r_a) + SW'(r_b) + SW'(r_pin1);
            a_new = r_a - DW'(old_pix) + DW'(mid_pix);
            b_new = r_b - DW'(mid_pix) + DW'(r_pin1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= s0_valid;
            r_v2 <= r_v1 && r_emit1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_first1 <= s0_first;
            r_emit1  <= s0_emit;
            r_last1  <= s0_last;
            r_oldc1  <= s0_oldc;
            r_pin1   <= s0_pin;
            if (r_v1) begin
                r_s <= s_new;
                r_a <= a_new;
                r_b <= b_new;
                if (r_first1) begin
                    r_p0 <= r_pin1;
                end
            end
            r_s2    <= s_new;
            r_last2 <= r_last1;
            r_prod  <= XW'(r_s2) * XW'(i_cfg.mul);
            r_last3 <= r_last2;
            r_pix4  <= PW'(r_prod >> i_cfg.shr);
            r_last4 <= r_last3;
        end
    end

    assign o_out_valid = r_v4;
    assign o_pixel_out = r_pix4;
    assign o_row_last  = r_last4;

    a_first_no_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_first1 |-> !r_emit1)
        else $error("The first pixel of a row produced an output column.");

    a_last_emits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_last1 |-> r_emit1)
        else $error("The final flush step of a row did not produce an output.");

    a_flush_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fl <= i_cfg.radius)
        else $error("The flush counter exceeds the blur radius.");

endmodule

@@ hw/rtl/stack_blur_row_filter.sv @@
// Column x is output after pixel x+r is transferred, via the queue, sum and scale stages.
// Throughput: one pixel per cycle unless stalled; a row end adds an r-step back end flush.
// The window memory has two read ports and one write port and sets the one-per-cycle rate.
// Reset is synchronous and active low; it clears control state and sets the radius to 2.
// The window memory is not cleared, since every read hits a pixel of the current row.
// ----------------------------------------------------------------------------
// Stack blur row filter
// Horizontal stack blur of 8-bit grayscale rows with edge replication.
// ----------------------------------------------------------------------------
module stack_blur_row_filter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [sbr_pkg::PIX_W-1:0]    i_pixel_in,
    input  logic                         i_row_end,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [sbr_pkg::PIX_W-1:0]    o_pixel_out,
    output logic                         o_row_last,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sbr_pkg::RADIUS_W-1:0] i_blur_radius
);

    sbr_pkg::t_cmd push_cmd;
    sbr_pkg::t_cmd head_cmd;
    sbr_pkg::t_cfg cfg;
    logic          push;
    logic          q_ready;
    logic          q_valid;
    logic          q_pop;

    sbr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_in    (i_pixel_in),
        .i_row_end     (i_row_end),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_blur_radius (i_blur_radius),
        .i_q_ready     (q_ready),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .o_cfg         (cfg)
    );

    sbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (q_pop)
    );

    sbr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (head_cmd),
        .o_q_pop     (q_pop),
        .i_cfg       (cfg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_out (o_pixel_out),
        .o_row_last  (o_row_last)
    );

endmodule
